>>> sv/aiaf_pkg.sv
`timescale 1ns / 1ps
// package for the alu with flags unit: command codes, store sizing and shared types
// no dependencies
package aiaf_pkg;

   localparam int VAR_COUNT = 256;
   localparam int VAR_AW    = 8;

   localparam logic [4:0] CMD_LSL   = 5'd0;
   localparam logic [4:0] CMD_LSR   = 5'd1;
   localparam logic [4:0] CMD_ASR   = 5'd2;
   localparam logic [4:0] CMD_ROR   = 5'd3;
   localparam logic [4:0] CMD_RRX   = 5'd4;
   localparam logic [4:0] CMD_AND   = 5'd5;
   localparam logic [4:0] CMD_OR    = 5'd6;
   localparam logic [4:0] CMD_XOR   = 5'd7;
   localparam logic [4:0] CMD_BIC   = 5'd8;
   localparam logic [4:0] CMD_CLZ   = 5'd9;
   localparam logic [4:0] CMD_ADD   = 5'd10;
   localparam logic [4:0] CMD_ADC   = 5'd11;
   localparam logic [4:0] CMD_SUB   = 5'd12;
   localparam logic [4:0] CMD_SBC   = 5'd13;
   localparam logic [4:0] CMD_MOV   = 5'd14;
   localparam logic [4:0] CMD_MVN   = 5'd15;
   localparam logic [4:0] CMD_QADD  = 5'd16;
   localparam logic [4:0] CMD_QSUB  = 5'd17;
   localparam logic [4:0] CMD_MUL   = 5'd18;
   localparam logic [4:0] CMD_MULL  = 5'd19;
   localparam logic [4:0] CMD_STFL  = 5'd20;
   localparam logic [4:0] CMD_LDFL  = 5'd21;
   localparam logic [4:0] CMD_LDSTK = 5'd22;
   localparam logic [4:0] CMD_COPY  = 5'd23;

   typedef struct packed {
      logic [4:0]  command;
      logic [7:0]  dest_index;
      logic        dest_present;
      logic [7:0]  high_dest_index;
      logic        high_dest_present;
      logic [3:0]  flag_mask;
      logic        option_main;
      logic        shift_down_half;
   } item_type;

   typedef struct packed {
      logic [31:0] low;
      logic [31:0] high;
      logic        wr_low;
      logic        wr_high;
      logic [3:0]  flags;
      logic        q;
   } alu_out_type;

endpackage

>>> sv/aiaf_alu.sv
`timescale 1ns / 1ps
// execute logic: one operation on two fetched operands, next flags and store writes
// depends on aiaf_pkg
module aiaf_alu import aiaf_pkg::*; (
   input  item_type    item,
   input  logic [31:0] a,
   input  logic [31:0] b,
   input  logic [3:0]  flags,
   input  logic        q,
   output alu_out_type res
);

   logic [31:0] r, hi;
   logic        writes, has_hi;
   logic [3:0]  nf;
   logic        nq;
   logic        cin;
   logic [32:0] tmp33;
   logic [32:0] lsl33;
   logic [32:0] lsr33;
   logic [63:0] rr64;
   logic [65:0] prod66;
   logic [63:0] p64;
   logic [4:0]  sh;
   logic        big, eq32, nz;
   logic [31:0] sh_r;
   logic        sh_c;
   logic [5:0]  lz;
   logic [3:0]  m;

   always_comb begin
      lz = 6'd32;
      for (int i = 0; i < 32; i++) begin
         if (a[i]) begin
            lz = 6'(31 - i);
         end
      end
   end

   always_comb begin
      m     = item.flag_mask;
      cin   = flags[1];
      sh    = b[4:0];
      big   = (b[31:5] != 27'd0);
      eq32  = (b == 32'd32);
      nz    = (b != 32'd0);
      lsl33 = {1'b0, a} << sh;
      lsr33 = {a, 1'b0} >> sh;
      rr64  = {a, a} >> sh;
      prod66 = $signed({item.option_main & a[31], a}) *
               $signed({item.option_main & b[31], b});
      p64   = prod66[63:0];
      if (item.shift_down_half) begin
         p64 = {{16{item.option_main & p64[63]}}, p64[63:16]};
      end
      sh_r  = a;
      sh_c  = 1'b0;
      unique case (item.command[1:0])
         2'd0: begin
            if (big) begin
               sh_r = 32'd0;
               sh_c = eq32 & a[0];
            end else begin
               sh_r = lsl33[31:0];
               sh_c = lsl33[32];
            end
         end
         2'd1: begin
            if (big) begin
               sh_r = 32'd0;
               sh_c = eq32 & a[31];
            end else begin
               sh_r = lsr33[32:1];
               sh_c = lsr33[0];
            end
         end
         2'd2: begin
            if (big) begin
               sh_r = {32{a[31]}};
               sh_c = a[31];
            end else begin
               sh_r = 32'($signed(a) >>> sh);
               sh_c = lsr33[0];
            end
         end
         default: begin
            sh_r = rr64[31:0];
            sh_c = rr64[31];
         end
      endcase

      r      = 32'd0;
      hi     = 32'd0;
      writes = 1'b1;
      has_hi = 1'b0;
      nf     = flags;
      nq     = q;
      tmp33  = 33'd0;
      unique case (item.command)
         CMD_LSL, CMD_LSR, CMD_ASR, CMD_ROR: begin
            r = nz ? sh_r : a;
            if (item.option_main && nz) begin
               nf[1] = sh_c;
            end
         end
         CMD_RRX: begin
            r = {cin, a[31:1]};
            if (item.option_main) begin
               nf[1] = a[0];
            end
         end
         CMD_AND, CMD_OR, CMD_XOR, CMD_BIC, CMD_MOV, CMD_MVN, CMD_MUL: begin
            unique case (item.command)
               CMD_AND: r = a & b;
               CMD_OR:  r = a | b;
               CMD_XOR: r = a ^ b;
               CMD_BIC: r = a & ~b;
               CMD_MOV: r = a;
               CMD_MVN: r = ~a;
               default: r = p64[31:0] ^ 32'd0;
            endcase
            if (item.command == CMD_MUL) begin
               r = prod66[31:0];
            end
            if (m[3]) nf[3] = r[31];
            if (m[2]) nf[2] = (r == 32'd0);
         end
         CMD_CLZ: begin
            r = {26'd0, lz};
         end
         CMD_ADD, CMD_ADC: begin
            tmp33 = {1'b0, a} + {1'b0, b} +
                    {32'd0, (item.command == CMD_ADC) & cin};
            r = tmp33[31:0];
            if (m[3]) nf[3] = r[31];
            if (m[2]) nf[2] = (r == 32'd0);
            if (m[1]) nf[1] = tmp33[32];
            if (m[0]) nf[0] = ~(a[31] ^ b[31]) & (a[31] ^ r[31]);
         end
         CMD_SUB, CMD_SBC: begin
            tmp33 = {1'b0, a} - {1'b0, b} -
                    {32'd0, (item.command == CMD_SBC) & ~cin};
            r = tmp33[31:0];
            if (m[3]) nf[3] = r[31];
            if (m[2]) nf[2] = (r == 32'd0);
            if (m[1]) nf[1] = ~tmp33[32];
            if (m[0]) nf[0] = (a[31] ^ b[31]) & (a[31] ^ r[31]);
         end
         CMD_QADD, CMD_QSUB: begin
            if (item.command == CMD_QADD) begin
               tmp33 = {a[31], a} + {b[31], b};
            end else begin
               tmp33 = {a[31], a} - {b[31], b};
            end
            if (tmp33[32] != tmp33[31]) begin
               r = tmp33[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
               if (m[0]) nq = 1'b1;
            end else begin
               r = tmp33[31:0];
            end
         end
         CMD_MULL: begin
            r      = p64[31:0];
            hi     = p64[63:32];
            has_hi = 1'b1;
            if (m[3]) nf[3] = p64[63];
            if (m[2]) nf[2] = (p64 == 64'd0);
         end
         CMD_STFL: begin
            nf     = (flags & ~m) | (a[31:28] & m);
            writes = 1'b0;
         end
         CMD_LDFL: begin
            r = (a & ~{m, 28'd0}) | {flags & m, 28'd0};
         end
         CMD_LDSTK: begin
            r = a | {4'd0, item.option_main & q, 27'd0};
         end
         CMD_COPY: begin
            r = a;
         end
         default: begin
            writes = 1'b0;
         end
      endcase

      res.wr_low  = writes & item.dest_present;
      res.wr_high = has_hi & item.high_dest_present;
      res.low     = res.wr_low ? r : 32'd0;
      res.high    = res.wr_high ? hi : 32'd0;
      res.flags   = nf;
      res.q       = nq;
   end

endmodule

>>> sv/arm_ir_alu_with_flags_unit.sv
`timescale 1ns / 1ps
// top level of the alu with flags unit: variable store, operand forwarding, output register
// depends on aiaf_pkg and aiaf_alu
// result path: store read and item registered at accept, then executed into the output register when it fires
// throughput: 1 item per cycle unless rsp_ready stalls the output; the store is two registered-read
// memories (low and high writes) with the last item's writes forwarded to the next one
// reset clears flags, sticky q, per-entry valid bits (store reads as zero) and pipeline valids
module arm_ir_alu_with_flags_unit import aiaf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [4:0]  req_command,
   input  logic        req_first_is_immediate,
   input  logic [31:0] req_first_arg,
   input  logic        req_second_is_immediate,
   input  logic [31:0] req_second_arg,
   input  logic [7:0]  req_dest_index,
   input  logic        req_dest_present,
   input  logic [7:0]  req_high_dest_index,
   input  logic        req_high_dest_present,
   input  logic [3:0]  req_flag_mask,
   input  logic        req_option_main,
   input  logic        req_shift_down_half,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_low_result,
   output logic [31:0] rsp_high_result,
   output logic [3:0]  rsp_flags_nzcv,
   output logic        rsp_sticky_q
);

   logic [31:0] mem_lo [VAR_COUNT];
   logic [31:0] mem_hi [VAR_COUNT];
   logic [VAR_COUNT-1:0] valid_ff, valid_in;
   logic [VAR_COUNT-1:0] hsel_ff, hsel_in;

   logic        s1_valid_ff, s1_valid_in;
   item_type    s1_item_ff;
   logic        s1_aimm_ff, s1_bimm_ff;
   logic [31:0] s1_aarg_ff, s1_barg_ff;
   logic [31:0] rd_alo_ff, rd_ahi_ff, rd_blo_ff, rd_bhi_ff;

   logic              wl_en_ff, wh_en_ff;
   logic [VAR_AW-1:0] wl_addr_ff, wh_addr_ff;
   logic [31:0]       wl_data_ff, wh_data_ff;

   logic [3:0]  flags_ff;
   logic        q_ff;

   logic        out_valid_ff;
   logic [31:0] out_low_ff, out_high_ff;
   logic [3:0]  out_flags_ff;
   logic        out_q_ff;

   logic        advance, fire, accept;
   logic [31:0] op_a, op_b;
   alu_out_type res;
   item_type    req_item;

   function automatic logic [31:0] fetch_op(
      input logic        imm,
      input logic [31:0] arg,
      input logic [31:0] lo_q,
      input logic [31:0] hi_q,
      input logic        ent_valid,
      input logic        ent_hsel,
      input logic        wl_en,
      input logic [VAR_AW-1:0] wl_addr,
      input logic [31:0] wl_data,
      input logic        wh_en,
      input logic [VAR_AW-1:0] wh_addr,
      input logic [31:0] wh_data
   );
      logic [31:0] v;
      if (imm) begin
         v = arg;
      end else if (arg >= 32'(VAR_COUNT)) begin
         v = 32'd0;
      end else if (wh_en && wh_addr == arg[VAR_AW-1:0]) begin
         v = wh_data;
      end else if (wl_en && wl_addr == arg[VAR_AW-1:0]) begin
         v = wl_data;
      end else if (!ent_valid) begin
         v = 32'd0;
      end else begin
         v = ent_hsel ? hi_q : lo_q;
      end
      return v;
   endfunction

   assign advance   = !out_valid_ff || rsp_ready;
   assign fire      = s1_valid_ff && advance;
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   assign req_item.command           = req_command;
   assign req_item.dest_index        = req_dest_index;
   assign req_item.dest_present      = req_dest_present;
   assign req_item.high_dest_index   = req_high_dest_index;
   assign req_item.high_dest_present = req_high_dest_present;
   assign req_item.flag_mask         = req_flag_mask;
   assign req_item.option_main       = req_option_main;
   assign req_item.shift_down_half   = req_shift_down_half;

   assign op_a = fetch_op(s1_aimm_ff, s1_aarg_ff, rd_alo_ff, rd_ahi_ff,
                          valid_ff[s1_aarg_ff[VAR_AW-1:0]], hsel_ff[s1_aarg_ff[VAR_AW-1:0]],
                          wl_en_ff, wl_addr_ff, wl_data_ff, wh_en_ff, wh_addr_ff, wh_data_ff);
   assign op_b = fetch_op(s1_bimm_ff, s1_barg_ff, rd_blo_ff, rd_bhi_ff,
                          valid_ff[s1_barg_ff[VAR_AW-1:0]], hsel_ff[s1_barg_ff[VAR_AW-1:0]],
                          wl_en_ff, wl_addr_ff, wl_data_ff, wh_en_ff, wh_addr_ff, wh_data_ff);

   aiaf_alu u_alu (
      .item  (s1_item_ff),
      .a     (op_a),
      .b     (op_b),
      .flags (flags_ff),
      .q     (q_ff),
      .res   (res)
   );

   // store read on accept, write on execute
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_alo_ff <= mem_lo[req_first_arg[VAR_AW-1:0]];
         rd_blo_ff <= mem_lo[req_second_arg[VAR_AW-1:0]];
      end
      if (fire && res.wr_low) begin
         mem_lo[s1_item_ff.dest_index] <= res.low;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ahi_ff <= mem_hi[req_first_arg[VAR_AW-1:0]];
         rd_bhi_ff <= mem_hi[req_second_arg[VAR_AW-1:0]];
      end
      if (fire && res.wr_high) begin
         mem_hi[s1_item_ff.high_dest_index] <= res.high;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      hsel_in  = hsel_ff;
      if (fire && res.wr_low) begin
         valid_in[s1_item_ff.dest_index] = 1'b1;
         hsel_in[s1_item_ff.dest_index]  = 1'b0;
      end
      if (fire && res.wr_high) begin
         valid_in[s1_item_ff.high_dest_index] = 1'b1;
         hsel_in[s1_item_ff.high_dest_index]  = 1'b1;
      end
      s1_valid_in = accept ? 1'b1 : (fire ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         hsel_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         flags_ff     <= 4'd0;
         q_ff         <= 1'b0;
         out_valid_ff <= 1'b0;
         wl_en_ff     <= 1'b0;
         wh_en_ff     <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         hsel_ff     <= hsel_in;
         s1_valid_ff <= s1_valid_in;
         if (fire) begin
            flags_ff     <= res.flags;
            q_ff         <= res.q;
            out_valid_ff <= 1'b1;
            wl_en_ff     <= res.wr_low;
            wh_en_ff     <= res.wr_high;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_item;
         s1_aimm_ff <= req_first_is_immediate;
         s1_bimm_ff <= req_second_is_immediate;
         s1_aarg_ff <= req_first_arg;
         s1_barg_ff <= req_second_arg;
      end
      if (fire) begin
         wl_addr_ff   <= s1_item_ff.dest_index;
         wl_data_ff   <= res.low;
         wh_addr_ff   <= s1_item_ff.high_dest_index;
         wh_data_ff   <= res.high;
         out_low_ff   <= res.low;
         out_high_ff  <= res.high;
         out_flags_ff <= res.flags;
         out_q_ff     <= res.q;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_low_result  = out_low_ff;
   assign rsp_high_result = out_high_ff;
   assign rsp_flags_nzcv  = out_flags_ff;
   assign rsp_sticky_q    = out_q_ff;

endmodule
